// ----- hdl/sps_pkg.sv -----
// shared types and constants for the sha1 prefix nonce search core
package sps_pkg;
    localparam int unsigned NONCE_W = 64;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned SCHED_N = 16;
    localparam int unsigned DIGEST_BYTES = 20;
    localparam int unsigned MAX_PREFIX_BYTES = 6;

    // configuration register indexes
    localparam logic [2:0] REG_PREFIX_BYTES = 3'd0;
    localparam logic [2:0] REG_PREFIX_LEN   = 3'd1;
    localparam logic [2:0] REG_TARGET_W0    = 3'd2;
    localparam logic [2:0] REG_TARGET_W1    = 3'd3;
    localparam logic [2:0] REG_TARGET_W2    = 3'd4;
    localparam logic [2:0] REG_TARGET_LEN   = 3'd5;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    // control from the sequencer to the schedule window cells
    typedef struct packed {
        logic load;   // load the padded block
        logic shift;  // advance the window by one word
    } t_sched_ctl;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_hash_st;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        if (t < 7'd20)      round_k = 32'h5A827999;
        else if (t < 7'd40) round_k = 32'h6ED9EBA1;
        else if (t < 7'd60) round_k = 32'h8F1BBCDC;
        else                round_k = 32'hCA62C1D6;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        if (t < 7'd20)      round_f = (b & c) | (~b & d);
        else if (t < 7'd40) round_f = b ^ c ^ d;
        else if (t < 7'd60) round_f = (b & c) | (b & d) | (c & d);
        else                round_f = b ^ c ^ d;
    endfunction
endpackage

// ----- hdl/sps_sched_cell.sv -----
// one word cell of the message schedule window
module sps_sched_cell import sps_pkg::*; (
    input  logic        i_clk,
    input  t_sched_ctl  i_ctl,
    input  logic [31:0] i_load_word,
    input  logic [31:0] i_next_word,
    output logic [31:0] o_word
);
    logic [31:0] r_word;

    // load or take the neighbor's word
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_word <= i_load_word;
        end else if (i_ctl.shift) begin
            r_word <= i_next_word;
        end
    end

    assign o_word = r_word;
endmodule

// ----- hdl/sps_sched_chain.sv -----
// sixteen word schedule window built as a shifting chain of cells
module sps_sched_chain import sps_pkg::*; (
    input  logic           i_clk,
    input  t_sched_ctl     i_ctl,
    input  logic [511:0]   i_block,
    output logic [31:0]    o_w
);
    logic [31:0] w_cell [SCHED_N];
    logic [31:0] w_feed [SCHED_N];
    logic [31:0] w_new;

    // new word from taps t-3, t-8, t-14, t-16 (cell 0 is the oldest)
    assign w_new = rotl(w_cell[13] ^ w_cell[8] ^ w_cell[2] ^ w_cell[0], 1);

    genvar g;
    generate
        for (g = 0; g < SCHED_N; g++) begin : g_cell
            if (g == SCHED_N - 1) begin : g_tail
                assign w_feed[g] = w_new;
            end else begin : g_mid
                assign w_feed[g] = w_cell[g + 1];
            end
            sps_sched_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (i_ctl),
                .i_load_word (i_block[511 - 32*g -: 32]),
                .i_next_word (w_feed[g]),
                .o_word      (w_cell[g])
            );
        end
    endgenerate

    assign o_w = w_cell[0];
endmodule

// ----- hdl/sha1_prefix_pow_search_core.sv -----
// sha1 prefix nonce search core: top level with sequencer, round unit and compare
//  channel | dir | beat contents (low bit up)
//  s_axis  | in  | tdata: range_start[63:0], range_end[127:64]
//  m_axis  | out | tdata: found[0], nonce[64:1], zero fill to 72 bits
//  cfg     | in  | i_cfg_we, i_cfg_idx (register index), i_cfg_data[63:0]
// each nonce runs one range check, one load, 80 rounds on a single round unit,
// one digest add and one compare. a job without a hit repeats these for every nonce
// in the range and ends with a final range check, after the idle state takes the beat.
// reset is synchronous and active low; it clears control and configuration.
// a result waits in the output register; a new job is taken once it is delivered.
module sha1_prefix_pow_search_core import sps_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // range_start, range_end
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // found, nonce, zero fill
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data
);
    localparam int unsigned PFX_W = 8 * MAX_PREFIX_BYTES;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_LOAD  = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_CMP   = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [PFX_W-1:0] r_pfx;
    logic [2:0]    r_plen;
    logic [63:0]   r_tw0, r_tw1;
    logic [31:0]   r_tw2;
    logic [4:0]    r_tlen;
    logic [63:0]   r_nonce, r_end;
    logic [6:0]    r_round;
    t_hash_st      r_h;
    logic          r_out_valid, r_found;
    logic [63:0]   r_out_nonce;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pfx <= '0; r_plen <= '0; r_tw0 <= '0; r_tw1 <= '0; r_tw2 <= '0; r_tlen <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PREFIX_BYTES: r_pfx  <= i_cfg_data[PFX_W-1:0];
                REG_PREFIX_LEN:   r_plen <= i_cfg_data[2:0];
                REG_TARGET_W0:    r_tw0  <= i_cfg_data;
                REG_TARGET_W1:    r_tw1  <= i_cfg_data;
                REG_TARGET_W2:    r_tw2  <= i_cfg_data[31:0];
                REG_TARGET_LEN:   r_tlen <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // padded block: prefix, nonce little endian, 0x80, zeros, bit length
    logic [3:0]   w_plen;
    logic [4:0]   w_tlen;
    logic [511:0] w_block;
    always_comb begin
        w_plen = (r_plen > 3'(MAX_PREFIX_BYTES)) ? 4'(MAX_PREFIX_BYTES) : {1'b0, r_plen};
        w_tlen = (r_tlen > 5'(DIGEST_BYTES)) ? 5'(DIGEST_BYTES) : r_tlen;
        w_block = '0;
        for (int i = 0; i < MAX_PREFIX_BYTES; i++) begin
            if (4'(i) < w_plen) w_block[511 - 8*i -: 8] = r_pfx[8*i +: 8];
        end
        for (int j = 0; j < 14; j++) begin
            if (4'(j) >= w_plen && 4'(j) < w_plen + 4'd8)
                w_block[511 - 8*j -: 8] = r_nonce[8*(j - int'(w_plen)) +: 8];
            if (4'(j) == w_plen + 4'd8) w_block[511 - 8*j -: 8] = 8'h80;
        end
        if (w_plen == 4'd6) w_block[511 - 8*14 -: 8] = 8'h80;
        w_block[15:0] = {9'd0, w_plen + 4'd8, 3'd0};
    end

    // schedule window
    t_sched_ctl  w_ctl;
    logic [31:0] w_w;
    assign w_ctl.load  = (r_state == S_LOAD);
    assign w_ctl.shift = (r_state == S_ROUND);

    sps_sched_chain u_sched (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_block (w_block),
        .o_w     (w_w)
    );

    // digest byte compare against target
    logic [159:0] w_dig, w_tgt;
    logic         w_match;
    always_comb begin
        w_dig = {r_h.a, r_h.b, r_h.c, r_h.d, r_h.e};
        w_tgt = {r_tw0, r_tw1, r_tw2};
        w_match = 1'b1;
        for (int i = 0; i < DIGEST_BYTES; i++) begin
            if (5'(i) < w_tlen && w_dig[159 - 8*i -: 8] != w_tgt[159 - 8*i -: 8])
                w_match = 1'b0;
        end
    end

    logic w_take;
    assign s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign w_take = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_take) n_state = S_CHECK;
            S_CHECK: n_state = (r_nonce < r_end) ? S_LOAD : S_IDLE;
            S_LOAD:  n_state = S_ROUND;
            S_ROUND: if (r_round == 7'd79) n_state = S_ADD;
            S_ADD:   n_state = S_CMP;
            S_CMP:   n_state = w_match ? S_IDLE : S_CHECK;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer, round unit and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_take) begin
                    r_nonce <= s_axis_tdata[63:0];
                    r_end   <= s_axis_tdata[127:64];
                end
                S_CHECK: if (!(r_nonce < r_end)) begin
                    r_out_valid <= 1'b1; r_found <= 1'b0; r_out_nonce <= '0;
                end
                S_LOAD: begin
                    r_round <= '0;
                    r_h <= '{H0, H1, H2, H3, H4};
                end
                S_ROUND: begin
                    r_h.a <= rotl(r_h.a, 5) + round_f(r_round, r_h.b, r_h.c, r_h.d)
                             + r_h.e + round_k(r_round) + w_w;
                    r_h.b <= r_h.a;
                    r_h.c <= rotl(r_h.b, 30);
                    r_h.d <= r_h.c;
                    r_h.e <= r_h.d;
                    r_round <= r_round + 7'd1;
                end
                S_ADD: r_h <= '{r_h.a + H0, r_h.b + H1, r_h.c + H2, r_h.d + H3, r_h.e + H4};
                S_CMP: begin
                    if (w_match) begin
                        r_out_valid <= 1'b1; r_found <= 1'b1; r_out_nonce <= r_nonce;
                    end else begin
                        r_nonce <= r_nonce + 64'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_nonce, r_found};

    // a result appears only at the end of a job
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> r_state == S_IDLE) else $error("result outside idle");
    // no new job while a result waits
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !s_axis_tready) else $error("job taken over pending result");
    // rounds end at eighty
    a_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ADD |-> r_round == 7'd80) else $error("round count wrong");
endmodule

// ----- dv/sha1_search_checker.sv -----
// checker for the sha1 prefix nonce search core: job prediction and result compare
module sha1_search_checker import sps_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // range_start, range_end
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [71:0]  m_axis_tdata,   // found, nonce, zero fill
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [63:0]  i_cfg_data,
    output int           o_errors
);
    typedef struct packed {
        logic        found;
        logic [63:0] nonce;
    } t_search_result;

    // local copy of the configuration
    logic [47:0] prefix_bytes;
    logic [2:0]  prefix_len;
    logic [63:0] target_w0;
    logic [63:0] target_w1;
    logic [31:0] target_w2;
    logic [4:0]  target_len;

    t_search_result pending_results[$];

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned s);
        return (x << s) | (x >> (32 - s));
    endfunction

    // digest of prefix bytes followed by the nonce, little-endian, as one padded block
    function automatic logic [159:0] message_digest(input logic [47:0] pfx,
                                                    input int unsigned plen,
                                                    input logic [63:0] n);
        logic [7:0]  blk [64];
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        int unsigned len;
        len = plen + 8;
        for (int i = 0; i < 64; i++) blk[i] = 8'h00;
        for (int i = 0; i < int'(plen); i++) blk[i] = pfx[8*i +: 8];
        for (int i = 0; i < 8; i++) blk[plen + i] = n[8*i +: 8];
        blk[len] = 8'h80;
        blk[63] = 8'(len * 8);
        for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        a = H0; b = H1; c = H2; d = H3; e = H4;
        for (int t = 0; t < 80; t++) begin
            if (t >= 16)
                w[t % 16] = rol32(w[(t-3) % 16] ^ w[(t-8) % 16] ^ w[(t-14) % 16] ^ w[t % 16], 1);
            if (t < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (t < 40) begin
                f = b ^ c ^ d;          k = 32'h6ED9EBA1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d;          k = 32'hCA62C1D6;
            end
            tmp = rol32(a, 5) + f + e + k + w[t % 16];
            e = d; d = c; c = rol32(b, 30); b = a; a = tmp;
        end
        return {H0 + a, H1 + b, H2 + c, H3 + d, H4 + e};
    endfunction

    // first nonce in [start, end) whose digest head equals the target head
    function automatic t_search_result search_job(input logic [63:0] start,
                                                  input logic [63:0] stop);
        t_search_result r;
        logic [159:0]   dig;
        logic [159:0]   tgt;
        int unsigned    plen, tlen;
        logic           hit;
        r = '0;
        plen = (prefix_len > 3'd6) ? 6 : prefix_len;
        tlen = (target_len > 5'd20) ? 20 : target_len;
        tgt = {target_w0, target_w1, target_w2};
        for (logic [63:0] n = start; n < stop; n++) begin
            dig = message_digest(prefix_bytes, plen, n);
            hit = 1'b1;
            for (int i = 0; i < int'(tlen); i++)
                if (dig[159 - 8*i -: 8] != tgt[159 - 8*i -: 8]) hit = 1'b0;
            if (hit) begin
                r.found = 1'b1;
                r.nonce = n;
                return r;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    initial o_errors = 0;

    // watch config writes, job beats and result beats
    always @(posedge i_clk) begin
        t_search_result want;
        if (!i_rst_n) begin
            prefix_bytes <= '0; prefix_len <= '0; target_w0 <= '0;
            target_w1 <= '0; target_w2 <= '0; target_len <= '0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PREFIX_BYTES: prefix_bytes <= i_cfg_data[47:0];
                    REG_PREFIX_LEN:   prefix_len   <= i_cfg_data[2:0];
                    REG_TARGET_W0:    target_w0    <= i_cfg_data;
                    REG_TARGET_W1:    target_w1    <= i_cfg_data;
                    REG_TARGET_W2:    target_w2    <= i_cfg_data[31:0];
                    REG_TARGET_LEN:   target_len   <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(search_job(s_axis_tdata[63:0], s_axis_tdata[127:64]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with no job outstanding");
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[0] !== want.found)
                        report_mismatch($sformatf("found %b, want %b", m_axis_tdata[0],
                                                  want.found));
                    if (m_axis_tdata[64:1] !== want.nonce)
                        report_mismatch($sformatf("nonce %h, want %h", m_axis_tdata[64:1],
                                                  want.nonce));
                    if (m_axis_tdata[71:65] !== 7'd0)
                        report_mismatch("nonzero fill bits");
                end
            end
        end
    end

    final if (pending_results.size() != 0)
        $display("%0d results never arrived", pending_results.size());

    // number of leftover expectations, checked separately by the testbench verdict
    function automatic int leftover();
        return pending_results.size();
    endfunction
endmodule

// ----- dv/sha1_prefix_pow_search_core_tb.sv -----
// testbench top: stimulus, idling, watchdog and verdict for the nonce search core
module sha1_prefix_pow_search_core_tb;
    import sps_pkg::*;

    localparam int WATCHDOG_LIMIT = 150000;
    localparam int HOLD_CYCLES    = 3000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = REG_PREFIX_BYTES;
    logic [63:0]  i_cfg_data = '0;

    int errors;
    int jobs_sent = 0;
    int results_seen = 0;
    int found_seen = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int quiet_cycles = 0;
    bit hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    sha1_prefix_pow_search_core dut (.*);

    sha1_search_checker u_checker (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_errors(errors)
    );

    // result counting and watchdog on stalled traffic
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            results_seen <= results_seen + 1;
            found_seen <= found_seen + m_axis_tdata[0];
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d jobs outstanding", jobs_sent - results_seen);
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random backpressure, with one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_job(input logic [63:0] start, input logic [63:0] stop);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stop, start};
        do @(posedge i_clk); while (!s_axis_tready);
        jobs_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_seen != jobs_sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_setting(input logic [47:0] pfx, input logic [2:0] plen,
                                input logic [63:0] t0, input logic [63:0] t1,
                                input logic [31:0] t2, input logic [4:0] tlen);
        write_reg(REG_PREFIX_BYTES, {16'd0, pfx});
        write_reg(REG_PREFIX_LEN, {61'd0, plen});
        write_reg(REG_TARGET_W0, t0);
        write_reg(REG_TARGET_W1, t1);
        write_reg(REG_TARGET_W2, {32'd0, t2});
        write_reg(REG_TARGET_LEN, {59'd0, tlen});
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_setting();
        logic [4:0] tlen;
        case ($urandom_range(9))
            0, 1:    tlen = 5'd0;
            2:       tlen = 5'd2;
            3:       tlen = 5'($urandom_range(21, 31));
            default: tlen = 5'd1;
        endcase
        load_setting({$urandom, 16'($urandom)}, 3'($urandom_range(0, 7)),
                     rand64(), rand64(), $urandom, tlen);
    endtask

    // mostly short ranges anywhere, some empty, a few long enough to hit one byte
    task automatic random_job();
        logic [63:0] start;
        int unsigned pick;
        start = rand64();
        pick  = $urandom_range(99);
        if (pick < 8)
            send_job(start, start - 64'($urandom_range(0, 3)));
        else if (pick < 10)
            send_job(start, start + 64'($urandom_range(100, 400)));
        else if (pick < 14)
            send_job(64'($urandom_range(0, 20)), 64'($urandom_range(0, 24)));
        else
            send_job(start, start + 64'($urandom_range(1, 4)));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty target: first nonce of any non-empty range matches
        load_setting('0, 3'd0, '0, '0, '0, 5'd0);
        send_job(64'd5, 64'd5);
        send_job(64'd9, 64'd3);
        send_job('1, '0);
        send_job(64'd0, 64'd1);
        send_job('1 - 64'd1, '1);
        send_job(64'd0, '1);
        send_job(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0002);
        wait_idle();

        // oversized prefix and target lengths saturate; full target never hits
        load_setting('1, 3'd7, '1, '1, '1, 5'd31);
        send_job(64'd0, 64'd3);
        send_job('1 - 64'd3, '1);
        send_job(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5557);
        wait_idle();

        // full six byte prefix, one byte target over a long range
        load_setting(48'h0123_4567_89AB, 3'd6, 64'h00FF_0000_0000_0000, '0, '0, 5'd1);
        send_job(64'd0, 64'd600);
        send_job(64'd1000, 64'd1300);
        wait_idle();
        load_setting('0, 3'd0, 64'hA5A5_0000_0000_0000, '1, '0, 5'd20);
        send_job(64'd0, 64'd2);
        wait_idle();

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 80 : 0;
            rx_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 14 : 0;
            for (int grp = 0; grp < 4; grp++) begin
                wait_idle();
                random_setting();
                for (int j = 0; j < 95; j++) begin
                    if (ph == 2 && grp == 0 && j == 10) hold_req = 1'b1;
                    random_job();
                end
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("ran %0d search jobs (%0d hits) over several prefix and target setups,",
                 jobs_sent, found_seen);
        $display("including empty ranges, range edges, saturated lengths and a long stall");
        if (errors == 0 && u_checker.leftover() == 0 && results_seen == jobs_sent)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
